[design/bba_pkg.sv]
// ============================================================================
// bba_pkg
// Shared widths, request opcodes and response status codes for the
// free-block bitmap allocator.
// ============================================================================
`default_nettype none

package bba_pkg;

  // Field widths
  localparam int OP_W   = 2;
  localparam int BN_W   = 10;
  localparam int CNT_W  = 11;
  localparam int ST_W   = 2;
  localparam int BASE_W = 12;

  // Block count after reset
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  // Shift used by the reciprocal multiply that splits a block number
  // into word index and bit index
  localparam int RECIP_SHIFT = 17;

  // Request opcodes
  localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK  = 2'd2;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd3;

  // Response status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_ZERO     = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd3;

endpackage

`default_nettype wire

[design/bba_if.sv]
// ============================================================================
// bba_if
// Request and response channels of the block bitmap allocator, each a
// valid/ready handshake with its payload.
// ============================================================================
`default_nettype none

interface bba_req_if;
  import bba_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] opcode;
  logic [BN_W-1:0] block_number;

  modport source (output valid, output opcode, output block_number, input ready);
  modport sink   (input valid, input opcode, input block_number, output ready);
endinterface

interface bba_rsp_if;
  import bba_pkg::*;

  logic            valid;
  logic            ready;
  logic [ST_W-1:0] status;
  logic            block_free;
  logic [BN_W-1:0] allocated_block;

  modport source (output valid, output status, output block_free,
                  output allocated_block, input ready);
  modport sink   (input valid, input status, input block_free,
                  input allocated_block, output ready);
endinterface

`default_nettype wire

[design/block_bitmap_allocator_core.sv]
// ============================================================================
// block_bitmap_allocator_core
// First-fit free-block bitmap held in one synchronous memory, one word per
// entry, with query, free, mark-used and allocate requests.
// ============================================================================
// Usage:
//   req carries one request (opcode, block_number); it is taken when
//   req.valid and req.ready are both high. One request is worked at a time.
//   rsp returns exactly one response per request from an output register,
//   so a new request is taken while the previous response still waits.
//   cfg_we/cfg_wdata write block_count; write it only while no request
//   is outstanding.
// Sequence (states after the request is taken):
//   free or mark-used rejected, or query out of range:      check, done
//   query, free or mark-used with a memory access:           check, read, modify, done
//   allocate: check, then scan with one bitmap word read per cycle and
//   a find-first-set inside the word, then done; rsp.valid is set from done.
// Reset: block_count returns to 1024 and a clearing pass writes every
//   bitmap word to zero (all blocks in use) with req.ready low.
// Stall: while rsp is held by the receiver, a finished response waits in
//   the work stage and no further request is taken until it moves.
// ============================================================================
`default_nettype none

module block_bitmap_allocator_core #(
  parameter int NUM_BLOCKS = 1024,
  parameter int WORD_BITS  = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [bba_pkg::CNT_W-1:0] cfg_wdata,
  bba_req_if.sink                  req,
  bba_rsp_if.source                rsp
);
  import bba_pkg::*;

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int IW        = $clog2(WORD_BITS);
  localparam int RECIP     = ((1 << RECIP_SHIFT) + WORD_BITS - 1) / WORD_BITS;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state;
  logic [CNT_W-1:0]     block_count;
  logic [OP_W-1:0]      op;
  logic [BN_W-1:0]      bnum;
  logic [BN_W-1:0]      quot;
  logic [IW-1:0]        bit_sel;
  logic [AW-1:0]        clr_addr;
  logic [AW-1:0]        scan_addr;
  logic [BASE_W-1:0]    scan_base;
  logic                 rd_pend;
  logic [AW-1:0]        rd_addr;
  logic [BASE_W-1:0]    rd_base;
  logic [WORD_BITS-1:0] rd_data;
  logic [ST_W-1:0]      res_status;
  logic                 res_free;
  logic [BN_W-1:0]      res_alloc;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];

  logic [CNT_W-1:0]     lim;
  logic                 bn_out;
  logic                 scan_go;
  logic [BASE_W-1:0]    rem;
  logic [WORD_BITS-1:0] avail;
  logic                 hit;
  logic [IW-1:0]        ffs_idx;
  logic [WORD_BITS-1:0] sel_mask;
  logic [WORD_BITS-1:0] ffs_mask;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 rsp_free_slot;

  // Clamp the configured count to the capacity
  assign lim    = (32'(block_count) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS) : block_count;
  assign bn_out = {1'b0, bnum} >= lim;

  assign scan_go       = scan_base < {1'b0, lim};
  assign rsp_free_slot = !rsp.valid || rsp.ready;
  assign req.ready     = (state == S_IDLE);

  // Keep only bits of the arriving word that lie below the count, then
  // pick the lowest free one
  assign rem = {1'b0, lim} - rd_base;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      avail[i] = rd_data[i] && (BASE_W'(i) < rem);
    end
    ffs_idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        ffs_idx = IW'(i);
      end
    end
  end

  assign hit      = rd_pend && (|avail);
  assign ffs_mask = WORD_BITS'(1) << ffs_idx;
  assign sel_mask = WORD_BITS'(1) << bit_sel;

  // Steer the memory ports from the current state
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = scan_addr;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(quot);
      end
      S_MOD: begin
        mem_waddr = AW'(quot);
        if (op == OP_FREE) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data | sel_mask;
        end else if (op == OP_MARK) begin
          mem_we    = 1'b1;
          mem_wdata = rd_data & ~sel_mask;
        end
      end
      S_SCAN: begin
        if (hit) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr;
          mem_wdata = rd_data & ~ffs_mask;
        end else if (scan_go) begin
          mem_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Bitmap memory with a registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= map_mem[mem_raddr];
    end
  end

  // Block count register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= CNT_RESET;
    end else if (cfg_we) begin
      block_count <= cfg_wdata;
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      rd_pend   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // Drop a taken response unless a new one replaces it this cycle
      if (rsp.ready && (state != S_DONE)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.opcode;
            bnum  <= req.block_number;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          // Split the block number into word and bit by reciprocal multiply
          quot       <= BN_W'((32'(bnum) * RECIP) >> RECIP_SHIFT);
          res_free   <= 1'b0;
          res_alloc  <= '0;
          scan_addr  <= '0;
          scan_base  <= '0;
          rd_pend    <= 1'b0;
          if (op == OP_ALLOC) begin
            res_status <= ST_OK;
            state      <= S_SCAN;
          end else if (op == OP_QUERY) begin
            res_status <= ST_OK;
            state      <= bn_out ? S_DONE : S_RD;
          end else if (bnum == '0) begin
            res_status <= ST_ZERO;
            state      <= S_DONE;
          end else if (bn_out) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            res_status <= ST_OK;
            state      <= S_RD;
          end
        end
        S_RD: begin
          bit_sel <= IW'(32'(bnum) - 32'(quot) * WORD_BITS);
          state   <= S_MOD;
        end
        S_MOD: begin
          if (op == OP_QUERY) begin
            res_free <= rd_data[bit_sel];
          end
          state <= S_DONE;
        end
        S_SCAN: begin
          if (hit) begin
            res_alloc <= BN_W'(rd_base + BASE_W'(ffs_idx));
            rd_pend   <= 1'b0;
            state     <= S_DONE;
          end else if (scan_go) begin
            // Issue the next word and advance
            rd_pend   <= 1'b1;
            rd_addr   <= scan_addr;
            rd_base   <= scan_base;
            scan_addr <= scan_addr + AW'(1);
            scan_base <= scan_base + BASE_W'(WORD_BITS);
          end else begin
            res_status <= ST_NO_SPACE;
            rd_pend    <= 1'b0;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          // Hand the response to the output register once it is free
          if (rsp_free_slot) begin
            rsp.valid           <= 1'b1;
            rsp.status          <= res_status;
            rsp.block_free      <= res_free;
            rsp.allocated_block <= res_alloc;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/bba_checker.sv]
// ============================================================================
// bba_checker
// Port-level checks on the block bitmap allocator, bound to the allocator core.
// ============================================================================
`default_nettype none

module bba_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [bba_pkg::ST_W-1:0]  rsp_status,
  input logic                      rsp_block_free,
  input logic [bba_pkg::BN_W-1:0]  rsp_allocated_block
);
  import bba_pkg::*;

  // Hold a stalled response steady
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_block_free) && $stable(rsp_allocated_block))
    else $error("response changed while stalled");

  // Keep requests out right after reset, at the start of the clearing pass
  a_clear_pass: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken right after reset");

  // Work one request at a time
  a_one_open: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is open");

  // Report a free block only with status ok and no allocated block
  a_free_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_block_free |-> rsp_status == ST_OK &&
      rsp_allocated_block == '0)
    else $error("free flag with bad status or block number");

  // Hand out a nonzero block only with status ok
  a_alloc_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_allocated_block != '0 |-> rsp_status == ST_OK)
    else $error("block number on failed request");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_status          (rsp.status),
  .rsp_block_free      (rsp.block_free),
  .rsp_allocated_block (rsp.allocated_block)
);

`default_nettype wire
